// ----- sv/finite_difference_first_derivative_macros.svh -----
// Assertion macros for the finite-difference derivative block
`ifndef FINITE_DIFFERENCE_FIRST_DERIVATIVE_MACROS_SVH
`define FINITE_DIFFERENCE_FIRST_DERIVATIVE_MACROS_SVH

// A stalled transfer keeps its valid and its payload
`define FDD_ASSERT_HOLD(label, vld, stl, sig) \
  label: assert property (@(posedge clk) disable iff (rst) \
    (vld && stl) |=> (vld && $stable(sig))) \
    else $error("stalled transfer changed");

// Plain implication checked every cycle out of reset
`define FDD_ASSERT_IMPL(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) \
    (cond) |-> (prop)) \
    else $error("implication violated");

`endif

// ----- sv/fdd_pkg.sv -----
// Shared types and constants of the finite-difference derivative block
`default_nettype none

package fdd_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 16;

  localparam logic [DATA_W-1:0] SCALE_RESET = 32'h0001_0000;

  typedef enum logic [1:0] {
    STN_ONE_SIDED,
    STN_SHIFTED,
    STN_CENTRAL
  } stencil_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
  } tag_t;

endpackage

`default_nettype wire

// ----- sv/fdd_front.sv -----
// Sample window, series counter and stencil issue sequencer
`default_nettype none

module fdd_front #(
  parameter int MAX_LEN      = 65536,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [fdd_pkg::DATA_W-1:0]   sample,
  input  logic                                last,
  input  logic                                issue_ready,
  output logic                                issue_valid,
  output fdd_pkg::stencil_t                   issue_sel,
  output fdd_pkg::tag_t                       issue_tag,
  output logic [4:0][SAMPLE_WIDTH-1:0]        win
);
  import fdd_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);
  localparam logic [CNT_W-1:0] FIRST_K = CNT_W'(4);
  localparam logic [CNT_W-1:0] BACK_K  = CNT_W'(2);

  logic [CNT_W-1:0] cnt, cnt_next;
  logic             p1_valid;
  stencil_t         p1_sel;
  logic [IDX_W-1:0] p1_idx;
  logic             p1_last;
  logic             accept, issue, done;

  assign issue    = p1_valid && issue_ready;
  assign done     = issue && (p1_sel == STN_CENTRAL);
  assign in_stall = p1_valid && !done;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (last) begin
      cnt_next = '0;
    end else if (cnt < CNT_MAX) begin
      cnt_next = CNT_W'(cnt + 1'b1);
    end else begin
      cnt_next = cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      p1_valid <= 1'b0;
      p1_sel   <= STN_CENTRAL;
    end else if (accept) begin
      cnt      <= cnt_next;
      p1_valid <= (cnt >= FIRST_K);
      p1_sel   <= (cnt == FIRST_K) ? STN_ONE_SIDED : STN_CENTRAL;
    end else if (issue) begin
      unique case (p1_sel)
        STN_ONE_SIDED: p1_sel <= STN_SHIFTED;
        STN_SHIFTED:   p1_sel <= STN_CENTRAL;
        default:       p1_valid <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 4; i++) begin
        win[i] <= win[i+1];
      end
      win[4]  <= SAMPLE_WIDTH'(sample);
      p1_idx  <= (cnt == FIRST_K) ? '0 : IDX_W'(cnt - BACK_K);
      p1_last <= last;
    end else if (issue && (p1_sel == STN_ONE_SIDED)) begin
      p1_idx <= IDX_W'(1);
    end else if (issue && (p1_sel == STN_SHIFTED)) begin
      p1_idx <= IDX_W'(2);
    end
  end

  assign issue_valid    = p1_valid;
  assign issue_sel      = p1_sel;
  assign issue_tag.idx  = p1_idx;
  assign issue_tag.last = p1_last && (p1_sel == STN_CENTRAL);

endmodule

`default_nettype wire

// ----- sv/fdd_stencil.sv -----
// Five-point weighted sum stage
`default_nettype none

module fdd_stencil #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                issue_valid,
  output logic                                issue_ready,
  input  fdd_pkg::stencil_t                   issue_sel,
  input  fdd_pkg::tag_t                       issue_tag,
  input  logic [4:0][SAMPLE_WIDTH-1:0]        win,
  output logic                                sum_valid,
  input  logic                                sum_ready,
  output logic signed [SAMPLE_WIDTH+7:0]      sum,
  output fdd_pkg::tag_t                       sum_tag
);
  import fdd_pkg::*;

  localparam int SUM_W = SAMPLE_WIDTH + 8;

  logic signed [SUM_W-1:0] w [5];
  logic signed [SUM_W-1:0] sum_next;

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      w[i] = SUM_W'(signed'(win[i]));
    end
    unique case (issue_sel)
      STN_ONE_SIDED: sum_next = SUM_W'(48) * w[1] + SUM_W'(16) * w[3]
                              - SUM_W'(25) * w[0] - SUM_W'(36) * w[2]
                              - SUM_W'(3) * w[4];
      STN_SHIFTED:   sum_next = SUM_W'(18) * w[2] + w[4]
                              - SUM_W'(3) * w[0] - SUM_W'(10) * w[1]
                              - SUM_W'(6) * w[3];
      STN_CENTRAL:   sum_next = w[0] - w[4] + SUM_W'(8) * (w[3] - w[1]);
      default:       sum_next = '0;
    endcase
  end

  assign issue_ready = !sum_valid || sum_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (issue_ready) begin
      sum_valid <= issue_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_ready) begin
      sum     <= sum_next;
      sum_tag <= issue_tag;
    end
  end

endmodule

`default_nettype wire

// ----- sv/fdd_scale.sv -----
// Scale multiply, rounding, saturation and result register
`default_nettype none

module fdd_scale #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int FRAC_BITS    = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sum_valid,
  output logic                                sum_ready,
  input  logic signed [SAMPLE_WIDTH+7:0]      sum,
  input  fdd_pkg::tag_t                       sum_tag,
  input  logic [fdd_pkg::DATA_W-1:0]          scale_cfg,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fdd_pkg::DATA_W-1:0]   derivative,
  output logic [fdd_pkg::IDX_W-1:0]           index,
  output logic                                saturated,
  output logic                                last_res
);
  import fdd_pkg::*;

  localparam int SUM_W  = SAMPLE_WIDTH + 8;
  localparam int MAG_W  = (SUM_W > 32) ? SUM_W : 33;
  localparam int HI_W   = MAG_W - 32;
  localparam int PROD_W = MAG_W + 33;
  localparam logic [PROD_W-1:0] RND     = (PROD_W'(1) << FRAC_BITS) >> 1;
  localparam logic [PROD_W-1:0] LIM_POS = PROD_W'(32'h7FFF_FFFF);
  localparam logic [PROD_W-1:0] LIM_NEG = PROD_W'(32'h8000_0000);

  logic rdy3, rdy4, rdy_out;

  logic             v3, neg3;
  logic [MAG_W-1:0] mag3;
  tag_t             tag3;
  logic [SUM_W-1:0] abs_val;

  logic                v4, neg4;
  logic [63:0]         pl;
  logic [HI_W+31:0]    ph;
  tag_t                tag4;

  logic [PROD_W-1:0]  total, shifted, limit;
  logic               over;
  logic [DATA_W-1:0]  res_mag;
  logic [DATA_W-1:0]  res;

  assign rdy_out   = !out_valid || !out_stall;
  assign rdy4      = !v4 || rdy_out;
  assign rdy3      = !v3 || rdy4;
  assign sum_ready = rdy3;

  assign abs_val = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  always_comb begin
    total   = (PROD_W'(ph) << 32) + PROD_W'(pl) + RND;
    shifted = total >> FRAC_BITS;
    limit   = neg4 ? LIM_NEG : LIM_POS;
    over    = shifted > limit;
    res_mag = over ? limit[DATA_W-1:0] : shifted[DATA_W-1:0];
    res     = neg4 ? DATA_W'(-res_mag) : res_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy3) begin
        v3 <= sum_valid;
      end
      if (rdy4) begin
        v4 <= v3;
      end
      if (rdy_out) begin
        out_valid <= v4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      neg3 <= sum[SUM_W-1];
      mag3 <= MAG_W'(abs_val);
      tag3 <= sum_tag;
    end
    if (rdy4) begin
      neg4 <= neg3;
      pl   <= 64'(mag3[31:0]) * 64'(scale_cfg);
      ph   <= (HI_W+32)'(mag3[MAG_W-1:32]) * (HI_W+32)'(scale_cfg);
      tag4 <= tag3;
    end
    if (rdy_out) begin
      derivative <= res;
      saturated  <= over;
      index      <= tag4.idx;
      last_res   <= tag4.last;
    end
  end

endmodule

`default_nettype wire

// ----- sv/finite_difference_first_derivative.sv -----
// Top level of the fourth-order finite-difference first derivative block
// Takes one Q16.16 sample and returns one derivative per cycle when neither side stalls, once
// five samples of a series are in; the fifth sample yields indices 0, 1 and 2 and holds the
// input stalled while the window stays put for the three stencils. A result goes through the
// window register, weighted sum, magnitude, split 32-bit scale multiply, then round and
// saturate into the result register. The scale register comes up as 1.0 and is written through
// its own port; the user must write it only while idle, which the block does not enforce.
`default_nettype none

module finite_difference_first_derivative #(
  parameter int MAX_LEN      = 65536,
  parameter int SAMPLE_WIDTH = 32,
  parameter int FRAC_BITS    = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [fdd_pkg::DATA_W-1:0]   sample,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fdd_pkg::DATA_W-1:0]   derivative,
  output logic [fdd_pkg::IDX_W-1:0]           index,
  output logic                                saturated,
  output logic                                last_res,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fdd_pkg::DATA_W-1:0]          scale
);
  import fdd_pkg::*;

  localparam int SUM_W = SAMPLE_WIDTH + 8;

  logic [DATA_W-1:0]            scale_cfg;
  logic                         issue_valid, issue_ready;
  stencil_t                     issue_sel;
  tag_t                         issue_tag;
  logic [4:0][SAMPLE_WIDTH-1:0] win;
  logic                         sum_valid, sum_ready;
  logic signed [SUM_W-1:0]      sum;
  tag_t                         sum_tag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_cfg <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      scale_cfg <= scale;
    end
  end

  fdd_front #(
    .MAX_LEN      (MAX_LEN),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .last        (last),
    .issue_ready (issue_ready),
    .issue_valid (issue_valid),
    .issue_sel   (issue_sel),
    .issue_tag   (issue_tag),
    .win         (win)
  );

  fdd_stencil #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_stencil (
    .clk         (clk),
    .rst         (rst),
    .issue_valid (issue_valid),
    .issue_ready (issue_ready),
    .issue_sel   (issue_sel),
    .issue_tag   (issue_tag),
    .win         (win),
    .sum_valid   (sum_valid),
    .sum_ready   (sum_ready),
    .sum         (sum),
    .sum_tag     (sum_tag)
  );

  fdd_scale #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_scale (
    .clk        (clk),
    .rst        (rst),
    .sum_valid  (sum_valid),
    .sum_ready  (sum_ready),
    .sum        (sum),
    .sum_tag    (sum_tag),
    .scale_cfg  (scale_cfg),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .derivative (derivative),
    .index      (index),
    .saturated  (saturated),
    .last_res   (last_res)
  );

endmodule

`default_nettype wire

// ----- sv/fdd_checker.sv -----
// Port-level checks of the derivative block and their binding
`default_nettype none

`include "finite_difference_first_derivative_macros.svh"

module fdd_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [fdd_pkg::DATA_W-1:0]   derivative,
  input logic [fdd_pkg::IDX_W-1:0]           index,
  input logic                                saturated,
  input logic                                last_res
);

  `FDD_ASSERT_HOLD(a_out_hold, out_valid, out_stall, {derivative, index, saturated, last_res})
  `FDD_ASSERT_IMPL(a_idle_after_reset, $past(rst), !out_valid)
  `FDD_ASSERT_IMPL(a_sat_at_limit, out_valid && saturated, derivative == 32'h7FFF_FFFF || derivative == 32'h8000_0000)

endmodule

bind finite_difference_first_derivative fdd_checker u_fdd_checker (.*);

`default_nettype wire
